### rtl/dd_pkg.sv
// Shared types, status codes and calendar helpers for the date difference unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dd_pkg;

   // Result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_BAD  = 2'd1;
   localparam logic [1:0] ST_LATE = 2'd2;

   // Field widths
   localparam int DAY_W  = 5;
   localparam int MON_W  = 4;
   localparam int YEAR_W = 14;

   // Calendar constants
   localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
   localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
   localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;
   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

   // Year / 100 by reciprocal: (y * 5243) >> 19 is exact for any 14-bit y
   localparam int          CENT_W     = 7;
   localparam logic [12:0] CENT_RECIP = 13'd5243;
   localparam int          CENT_SHIFT = 19;
   localparam logic [CENT_W-1:0] CENT_DIV = 7'd100;

   // Beat handed from the check stages to the difference stage
   typedef struct packed {
      logic              vld;
      logic              bad;     // either date invalid
      logic              late;    // birth date after current date
      logic [DAY_W-1:0]  plen;    // length of month before the current one
      logic [DAY_W-1:0]  nd;
      logic [MON_W-1:0]  nm;
      logic [YEAR_W-1:0] ny;
      logic [DAY_W-1:0]  bd;
      logic [MON_W-1:0]  bm;
      logic [YEAR_W-1:0] by;
   } dd_chk_type;

   // Days in month m; zero for a code that is no month
   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      begin
         case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
            MON_FEB:                                     len = leap ? 5'd29 : 5'd28;
            default:                                     len = 5'd0;
         endcase
         return len;
      end
   endfunction

endpackage

### rtl/dd_check.sv
// Check stages of the date difference unit: century split, leap years,
// date validity, ordering and borrow month length. Depends on dd_pkg.
`timescale 1ns / 1ps

module dd_check (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_vld,
   input  logic [dd_pkg::DAY_W-1:0]  now_day,
   input  logic [dd_pkg::MON_W-1:0]  now_month,
   input  logic [dd_pkg::YEAR_W-1:0] now_year,
   input  logic [dd_pkg::DAY_W-1:0]  birth_day,
   input  logic [dd_pkg::MON_W-1:0]  birth_month,
   input  logic [dd_pkg::YEAR_W-1:0] birth_year,
   output dd_pkg::dd_chk_type        chk
);
   import dd_pkg::*;

   // Stage 1 registers
   logic              s1_vld_ff, s1_vld_in;
   logic [DAY_W-1:0]  s1_nd_ff, s1_bd_ff;
   logic [MON_W-1:0]  s1_nm_ff, s1_bm_ff;
   logic [YEAR_W-1:0] s1_ny_ff, s1_by_ff;
   logic [CENT_W-1:0] s1_nq_ff, s1_nq_in, s1_bq_ff, s1_bq_in;

   // Stage 2 register
   dd_chk_type s2_ff, s2_in;

   logic [YEAR_W+12:0] nprod, bprod;
   logic [YEAR_W-1:0]  nrem, brem;
   logic               nleap, bleap, nok, bok;
   logic [MON_W-1:0]   pm;

   // Split each year into centuries by reciprocal multiply
   always_comb begin
      s1_vld_in = in_vld;
      nprod     = (YEAR_W+13)'(now_year) * (YEAR_W+13)'(CENT_RECIP);
      bprod     = (YEAR_W+13)'(birth_year) * (YEAR_W+13)'(CENT_RECIP);
      s1_nq_in  = nprod[CENT_SHIFT +: CENT_W];
      s1_bq_in  = bprod[CENT_SHIFT +: CENT_W];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
      end
      s1_nq_ff <= s1_nq_in;
      s1_bq_ff <= s1_bq_in;
      s1_nd_ff <= now_day;
      s1_nm_ff <= now_month;
      s1_ny_ff <= now_year;
      s1_bd_ff <= birth_day;
      s1_bm_ff <= birth_month;
      s1_by_ff <= birth_year;
   end

   // Leap years, validity, ordering and borrow month length
   always_comb begin
      nrem  = s1_ny_ff - YEAR_W'(s1_nq_ff) * YEAR_W'(CENT_DIV);
      brem  = s1_by_ff - YEAR_W'(s1_bq_ff) * YEAR_W'(CENT_DIV);
      nleap = ((s1_ny_ff[1:0] == 2'd0) && (nrem != '0)) ||
              ((nrem == '0) && (s1_nq_ff[1:0] == 2'd0));
      bleap = ((s1_by_ff[1:0] == 2'd0) && (brem != '0)) ||
              ((brem == '0) && (s1_bq_ff[1:0] == 2'd0));
      nok   = (s1_ny_ff != '0) && (s1_ny_ff <= YEAR_MAX) &&
              (s1_nm_ff != '0) && (s1_nm_ff <= MON_DEC) && (s1_nd_ff != '0) &&
              (s1_nd_ff <= month_len(s1_nm_ff, nleap));
      bok   = (s1_by_ff != '0) && (s1_by_ff <= YEAR_MAX) &&
              (s1_bm_ff != '0) && (s1_bm_ff <= MON_DEC) && (s1_bd_ff != '0) &&
              (s1_bd_ff <= month_len(s1_bm_ff, bleap));
      // December before January always has 31 days, so the current leap flag serves
      pm    = (s1_nm_ff == MON_JAN) ? MON_DEC : s1_nm_ff - 4'd1;

      s2_in.vld  = s1_vld_ff;
      s2_in.bad  = !(nok && bok);
      s2_in.late = {s1_ny_ff, s1_nm_ff, s1_nd_ff} < {s1_by_ff, s1_bm_ff, s1_bd_ff};
      s2_in.plen = month_len(pm, nleap);
      s2_in.nd   = s1_nd_ff;
      s2_in.nm   = s1_nm_ff;
      s2_in.ny   = s1_ny_ff;
      s2_in.bd   = s1_bd_ff;
      s2_in.bm   = s1_bm_ff;
      s2_in.by   = s1_by_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_ff.vld <= 1'b0;
      end else begin
         s2_ff.vld <= s2_in.vld;
      end
      s2_ff.bad  <= s2_in.bad;
      s2_ff.late <= s2_in.late;
      s2_ff.plen <= s2_in.plen;
      s2_ff.nd   <= s2_in.nd;
      s2_ff.nm   <= s2_in.nm;
      s2_ff.ny   <= s2_in.ny;
      s2_ff.bd   <= s2_in.bd;
      s2_ff.bm   <= s2_in.bm;
      s2_ff.by   <= s2_in.by;
   end

   assign chk = s2_ff;

endmodule

### rtl/dd_diff.sv
// Difference stage of the date difference unit: day and month borrows,
// status selection and the result register. Depends on dd_pkg.
`timescale 1ns / 1ps

module dd_diff (
   input  logic                      clock,
   input  logic                      reset,
   input  dd_pkg::dd_chk_type        chk,
   output logic                      out_vld,
   output logic [1:0]                out_status,
   output logic [dd_pkg::YEAR_W-1:0] out_years,
   output logic [dd_pkg::MON_W-1:0]  out_months,
   output logic [dd_pkg::DAY_W-1:0]  out_days
);
   import dd_pkg::*;

   logic              vld_ff, vld_in;
   logic [1:0]        status_ff, status_in;
   logic [YEAR_W-1:0] years_ff, years_in;
   logic [MON_W-1:0]  months_ff, months_in;
   logic [DAY_W-1:0]  days_ff, days_in;

   logic              dborrow, mborrow;
   logic [DAY_W:0]    dsum, bsum;
   logic [MON_W:0]    mneed, mnow;
   logic [DAY_W-1:0]  dres;
   logic [MON_W-1:0]  mres;

   // Borrow a month for days, then a year for months
   always_comb begin
      dborrow = chk.nd < chk.bd;
      dsum    = {1'b0, chk.nd} + {1'b0, chk.plen};
      bsum    = {1'b0, chk.bd};
      if (!dborrow) begin
         dres = chk.nd - chk.bd;
      end else if (dsum >= bsum) begin
         dres = DAY_W'(dsum - bsum);
      end else begin
         dres = '0;
      end
      mnow    = {1'b0, chk.nm};
      mneed   = {1'b0, chk.bm} + {{MON_W{1'b0}}, dborrow};
      mborrow = mnow < mneed;
      mres    = mborrow ? MON_W'(mnow + 5'd12 - mneed) : MON_W'(mnow - mneed);

      vld_in = chk.vld;
      if (chk.bad) begin
         status_in = ST_BAD;
      end else if (chk.late) begin
         status_in = ST_LATE;
      end else begin
         status_in = ST_OK;
      end
      if (status_in == ST_OK) begin
         years_in  = chk.ny - chk.by - {{(YEAR_W-1){1'b0}}, mborrow};
         months_in = mres;
         days_in   = dres;
      end else begin
         years_in  = '0;
         months_in = '0;
         days_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      status_ff <= status_in;
      years_ff  <= years_in;
      months_ff <= months_in;
      days_ff   <= days_in;
   end

   assign out_vld    = vld_ff;
   assign out_status = status_ff;
   assign out_years  = years_ff;
   assign out_months = months_ff;
   assign out_days   = days_ff;

endmodule

### rtl/date_difference_ymd_unit.sv
// Top level of the date difference unit: elapsed years, months and days.
// Depends on dd_pkg, dd_check and dd_diff.
//
//   channel   ports                         beat taken when
//   request   start, busy, req_*            start high, busy low
//   response  rsp_strobe, rsp_*             rsp_strobe high (one cycle)
//
// One beat per cycle passes through the stages in order:
// century split, calendar checks, then borrows and the result register.
// busy stays low; nothing in the pipeline ever waits.
// Synchronous reset drops all valid bits; payload registers are not reset.
// The receiver cannot stall, so every result shows for exactly one cycle.
`timescale 1ns / 1ps

module date_difference_ymd_unit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [dd_pkg::DAY_W-1:0]  req_now_day,
   input  logic [dd_pkg::MON_W-1:0]  req_now_month,
   input  logic [dd_pkg::YEAR_W-1:0] req_now_year,
   input  logic [dd_pkg::DAY_W-1:0]  req_birth_day,
   input  logic [dd_pkg::MON_W-1:0]  req_birth_month,
   input  logic [dd_pkg::YEAR_W-1:0] req_birth_year,
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic [dd_pkg::YEAR_W-1:0] rsp_years,
   output logic [dd_pkg::MON_W-1:0]  rsp_months,
   output logic [dd_pkg::DAY_W-1:0]  rsp_days
);
   import dd_pkg::*;

   dd_chk_type chk;
   logic       accept;

   // Take a beat every cycle that start is high
   assign busy   = 1'b0;
   assign accept = start && !busy;

   dd_check u_check (
      .clock       (clock),
      .reset       (reset),
      .in_vld      (accept),
      .now_day     (req_now_day),
      .now_month   (req_now_month),
      .now_year    (req_now_year),
      .birth_day   (req_birth_day),
      .birth_month (req_birth_month),
      .birth_year  (req_birth_year),
      .chk         (chk)
   );

   dd_diff u_diff (
      .clock      (clock),
      .reset      (reset),
      .chk        (chk),
      .out_vld    (rsp_strobe),
      .out_status (rsp_status),
      .out_years  (rsp_years),
      .out_months (rsp_months),
      .out_days   (rsp_days)
   );

   // Every accepted beat leaves as a result strobe
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe)
      else $error("accepted beat did not produce a result");

   // No result without an earlier accepted beat
   a_no_ghost : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3))
      else $error("result without accepted beat");

   // Failed status carries zero fields
   a_zero_fields : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != ST_OK) |->
         (rsp_years == '0 && rsp_months == '0 && rsp_days == '0))
      else $error("nonzero fields on failed status");

   // Good results stay within calendar ranges
   a_ranges : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_OK) |->
         (rsp_months <= 4'd11 && rsp_days <= 5'd30 && rsp_years <= 14'd9998))
      else $error("result field out of range");

endmodule
